// ===== hdl/mep_pkg.sv =====
`timescale 1ns / 1ps

package mep_pkg;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_MUL,
      ST_MAP_ADD,
      ST_ITER_MUL,
      ST_ITER_STEP,
      ST_FINISH
   } state_type;

   // configuration register indexes
   localparam logic [2:0] CSR_ITER_LIMIT     = 3'd0;
   localparam logic [2:0] CSR_WINDOW_LEFT    = 3'd1;
   localparam logic [2:0] CSR_WINDOW_RIGHT   = 3'd2;
   localparam logic [2:0] CSR_WINDOW_TOP     = 3'd3;
   localparam logic [2:0] CSR_WINDOW_BOTTOM  = 3'd4;

   // orbit check and colour constants
   localparam int          ORBIT_PERIOD  = 10;
   localparam int          PHASE_W       = 4;
   localparam logic [23:0] INSIDE_COLOUR = 24'hFFFFFF;
   localparam logic [7:0]  GREY_MAX      = 8'd255;

   typedef struct packed {
      logic [15:0]        iter_limit;
      logic signed [31:0] window_left;
      logic signed [31:0] window_right;
      logic signed [31:0] window_top;
      logic signed [31:0] window_bottom;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load_pix;
      logic map_mul;
      logic map_add;
      logic iter_mul;
      logic iter_step;
      logic load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic iter_go;
   } status_type;

   // clamp a wide signed value to 32 bit signed
   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > 65'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -65'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/mep_ctrl.sv =====
`timescale 1ns / 1ps

module mep_ctrl
   import mep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output slot can take a beat when empty or draining
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MAP_MUL;
         end
         ST_MAP_MUL:   state_in = ST_MAP_ADD;
         ST_MAP_ADD:   state_in = ST_ITER_MUL;
         ST_ITER_MUL:  state_in = ST_ITER_STEP;
         ST_ITER_STEP: begin
            state_in = status.iter_go ? ST_ITER_MUL : ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_pix = req_valid;
         end
         ST_MAP_MUL:   cmd.map_mul   = 1'b1;
         ST_MAP_ADD:   cmd.map_add   = 1'b1;
         ST_ITER_MUL:  cmd.iter_mul  = 1'b1;
         ST_ITER_STEP: cmd.iter_step = 1'b1;
         ST_FINISH:    cmd.load_out  = out_free;
         default:      cmd           = '0;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/mep_dpath.sv =====
`timescale 1ns / 1ps

module mep_dpath
   import mep_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 1024,
   parameter int IMAGE_HEIGHT = 1024,
   parameter int FRAC_BITS    = 28
) (
   input  logic        clock,
   input  logic [9:0]  pixel_x,
   input  logic [9:0]  pixel_y,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [23:0] colour,
   output logic [15:0] iteration_count,
   output logic        in_set
);

   // floor(log2(size)) as the mapping shift
   localparam int SHIFT_W = $clog2(IMAGE_WIDTH + 1) - 1;
   localparam int SHIFT_H = $clog2(IMAGE_HEIGHT + 1) - 1;
   localparam logic [64:0] ESC_LIMIT = 65'd4 << (2 * FRAC_BITS);

   logic [9:0]          x_ff, y_ff;
   logic signed [43:0]  prod_re_ff, prod_im_ff;
   logic signed [31:0]  cr_ff, ci_ff;
   logic signed [31:0]  zr_ff, zi_ff, sr_ff, si_ff;
   logic signed [63:0]  rr_ff, ii_ff, ri_ff;
   logic [15:0]         count_ff;
   logic [PHASE_W-1:0]  phase_ff;
   logic [23:0]         colour_ff;
   logic [15:0]         iter_out_ff;
   logic                in_set_ff;

   logic signed [32:0]  span_re, span_im;
   logic signed [43:0]  sh_re, sh_im;
   logic signed [44:0]  sum_re, sum_im;
   logic [64:0]         mag_sum;
   logic signed [64:0]  sq_diff, re_sh, im_sh, re_sum, im_sum;
   logic signed [31:0]  zr_next, zi_next;
   logic [PHASE_W-1:0]  phase_next;
   logic [15:0]         count_step;
   logic [7:0]          grey;
   logic                in_set_now;

   // window spans and mapping
   assign span_re = {cfg.window_right[31], cfg.window_right}
                  - {cfg.window_left[31], cfg.window_left};
   assign span_im = {cfg.window_bottom[31], cfg.window_bottom}
                  - {cfg.window_top[31], cfg.window_top};
   assign sh_re   = prod_re_ff >>> SHIFT_W;
   assign sh_im   = prod_im_ff >>> SHIFT_H;
   assign sum_re  = 45'(cfg.window_left) + 45'(sh_re);
   assign sum_im  = 45'(cfg.window_top) + 45'(sh_im);

   // escape test and next z from registered products
   assign mag_sum = {1'b0, rr_ff} + {1'b0, ii_ff};
   assign sq_diff = 65'(rr_ff) - 65'(ii_ff);
   assign re_sh   = sq_diff >>> FRAC_BITS;
   assign im_sh   = 65'(ri_ff) >>> (FRAC_BITS - 1);
   assign re_sum  = re_sh + 65'(cr_ff);
   assign im_sum  = im_sh + 65'(ci_ff);
   assign zr_next = sat32(re_sum);
   assign zi_next = sat32(im_sum);

   assign status.iter_go = (mag_sum < ESC_LIMIT) && (count_ff < cfg.iter_limit);

   assign count_step = count_ff + 16'd1;
   assign phase_next = (phase_ff == PHASE_W'(ORBIT_PERIOD - 1)) ? '0 : phase_ff + 1'b1;

   // result formatting
   assign in_set_now = (count_ff == cfg.iter_limit);
   assign grey       = (count_ff[15:9] != 7'd0) ? GREY_MAX : count_ff[8:1];

   always_ff @(posedge clock) begin
      if (cmd.load_pix) begin
         x_ff <= pixel_x;
         y_ff <= pixel_y;
      end
      // pixel times span
      if (cmd.map_mul) begin
         prod_re_ff <= 44'($signed({1'b0, x_ff})) * 44'(span_re);
         prod_im_ff <= 44'($signed({1'b0, y_ff})) * 44'(span_im);
      end
      // point c and orbit start
      if (cmd.map_add) begin
         cr_ff    <= sat32(65'(sum_re));
         ci_ff    <= sat32(65'(sum_im));
         zr_ff    <= '0;
         zi_ff    <= '0;
         sr_ff    <= '0;
         si_ff    <= '0;
         count_ff <= '0;
         phase_ff <= '0;
      end
      // squares and cross product
      if (cmd.iter_mul) begin
         rr_ff <= 64'(zr_ff) * 64'(zr_ff);
         ii_ff <= 64'(zi_ff) * 64'(zi_ff);
         ri_ff <= 64'(zr_ff) * 64'(zi_ff);
      end
      // one iteration with periodicity check
      if (cmd.iter_step && status.iter_go) begin
         zr_ff    <= zr_next;
         zi_ff    <= zi_next;
         phase_ff <= phase_next;
         if (phase_next == '0) begin
            sr_ff    <= zr_next;
            si_ff    <= zi_next;
            count_ff <= count_step;
         end else if (zr_next == sr_ff && zi_next == si_ff) begin
            count_ff <= cfg.iter_limit;
         end else begin
            count_ff <= count_step;
         end
      end
      // output register
      if (cmd.load_out) begin
         colour_ff   <= in_set_now ? INSIDE_COLOUR : {grey, grey, grey};
         iter_out_ff <= count_ff;
         in_set_ff   <= in_set_now;
      end
   end

   assign colour          = colour_ff;
   assign iteration_count = iter_out_ff;
   assign in_set          = in_set_ff;

endmodule

// ===== hdl/mandelbrot_escape_pixel.sv =====
`timescale 1ns / 1ps

// Mandelbrot escape-time pixel with orbit periodicity check.
// Request channel (req_): one beat carries a pixel column and row. The pixel
// is mapped into the window set by the csr_ registers, then z = z*z + c is
// iterated from zero until |z|^2 reaches 4, the count reaches the
// iteration limit, or z repeats the value saved every tenth iteration.
// Response channel (rsp_): one beat per request with colour, final count and
// the in-set flag.
// Sequencing: each iteration is a product stage on the three 32x32
// multipliers followed by an update stage. A new pixel is taken only after
// the previous one has finished, as req_ready is high only between pixels.
// Results sit in an output register: a new request is taken while a result
// waits, and a finished pixel holds in its last state while the receiver
// stalls with the output register full.
// Configuration (csr_): always ready, index 0 to 4, other indexes ignored;
// write only while no pixel is in flight.
// Reset: synchronous; registers go to limit 256 and window -2.0..1.0 by
// 1.125..-1.125, and any pixel in flight is dropped.

module mandelbrot_escape_pixel
   import mep_pkg::*;
#(
   parameter int IMAGE_WIDTH  = 1024,
   parameter int IMAGE_HEIGHT = 1024,
   parameter int FRAC_BITS    = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [9:0]  req_pixel_x,
   input  logic [9:0]  req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_colour,
   output logic [15:0] rsp_iteration_count,
   output logic        rsp_in_set,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ITER_LIMIT:     cfg_in.iter_limit     = csr_wdata[15:0];
            CSR_WINDOW_LEFT:    cfg_in.window_left    = csr_wdata;
            CSR_WINDOW_RIGHT:   cfg_in.window_right   = csr_wdata;
            CSR_WINDOW_TOP:     cfg_in.window_top     = csr_wdata;
            CSR_WINDOW_BOTTOM:  cfg_in.window_bottom  = csr_wdata;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.iter_limit     <= 16'd256;
         cfg_ff.window_left    <= -32'sd536870912;
         cfg_ff.window_right   <= 32'sd268435456;
         cfg_ff.window_top     <= 32'sd301989888;
         cfg_ff.window_bottom  <= -32'sd301989888;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mep_dpath #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dpath (
      .clock           (clock),
      .pixel_x         (req_pixel_x),
      .pixel_y         (req_pixel_y),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .colour          (rsp_colour),
      .iteration_count (rsp_iteration_count),
      .in_set          (rsp_in_set)
   );

   // result only loaded into a free or draining output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a waiting beat");

   // loaded result shows up as valid next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded result not presented");

   // inside points are white
   a_inside_white: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_set) |-> (rsp_colour == INSIDE_COLOUR))
      else $error("in-set result with wrong colour");

   // outside points are grey
   a_outside_grey: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_set) |->
         (rsp_colour[23:16] == rsp_colour[7:0] && rsp_colour[15:8] == rsp_colour[7:0]))
      else $error("outside result not grey");

endmodule
